### rtl/prc_pkg.sv
// ----------------------------------------------------------------------------
// PWM ramp controller package
// Shared constants, command codes and transfer types.
// ----------------------------------------------------------------------------
package prc_pkg;

   localparam int CHANNELS  = 64;
   localparam int ADDR_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W     = $clog2(CHANNELS + 1);
   localparam int CH_W      = 6;
   localparam int DUTY_W    = 8;
   localparam int LEN_W     = 16;
   localparam int MS_W      = 32;
   localparam int MUL_W     = DUTY_W + LEN_W;
   localparam int STEP_W    = $clog2(DUTY_W);

   localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;

   localparam logic [1:0] MODE_RAMP  = 2'd0;
   localparam logic [1:0] MODE_LEVEL = 2'd1;
   localparam logic [1:0] MODE_BREAK = 2'd2;
   localparam logic [1:0] MODE_TICK  = 2'd3;

   typedef struct packed {
      logic [1:0]        mode;
      logic [CH_W-1:0]   channel;
      logic [DUTY_W-1:0] target;
      logic [LEN_W-1:0]  duration_ms;
      logic              level;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0]   out_channel;
      logic [DUTY_W-1:0] duty;
      logic              last;
   } rsp_type;

   // per-channel record held in the channel memory
   typedef struct packed {
      logic [DUTY_W-1:0] cur;
      logic [DUTY_W-1:0] start_d;
      logic [DUTY_W-1:0] end_d;
      logic [MS_W-1:0]   start_ms;
      logic [LEN_W-1:0]  len;
   } rec_type;

   typedef struct packed {
      logic              start;
      logic [DUTY_W-1:0] start_d;
      logic [DUTY_W-1:0] end_d;
      logic [LEN_W-1:0]  len;
      logic [LEN_W-1:0]  elapsed;
   } interp_req_type;

   typedef struct packed {
      logic              done;
      logic [DUTY_W-1:0] quotient;
   } interp_rsp_type;

endpackage

### rtl/pwm_ramp_controller_unit.sv
// ----------------------------------------------------------------------------
// PWM ramp controller
// Ramp, level, break and tick commands over a bank of PWM channels; a tick
// walks the channels in order and emits each changed duty.
// ----------------------------------------------------------------------------
// A ramp command writes the channel record; a level write also gives its result
// once the record is written. Break visits every channel and freezes each ramping one.
// Tick skips idle channels and settled ramps, jumps to target once the fade time
// has run out and otherwise interpolates (8-step multiply, 8-step divide in
// the interpolation unit).
// One command in flight at a time; results cannot be stalled.
// Reset clears all channel state at once; no clearing pass is needed.
module pwm_ramp_controller_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  prc_pkg::req_type req_data,
   output logic             rsp_valid,
   output prc_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_SCAN,
      ST_LOOK,
      ST_CALC,
      ST_UPD
   } state_type;

   state_type                      state_ff, state_in;
   prc_pkg::req_type               req_ff, req_in;
   logic [prc_pkg::CNT_W-1:0]      idx_ff, idx_in;
   logic [prc_pkg::MS_W-1:0]       now_ff, now_in;
   logic [prc_pkg::CHANNELS-1:0]   ramping_ff, ramping_in;
   logic [prc_pkg::CHANNELS-1:0]   valid_ff, valid_in;
   prc_pkg::rec_type               rec_ff, rec_in;
   logic [prc_pkg::DUTY_W-1:0]     duty_ff, duty_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic [prc_pkg::CH_W-1:0]       pend_ch_ff, pend_ch_in;
   logic [prc_pkg::DUTY_W-1:0]     pend_duty_ff, pend_duty_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   prc_pkg::rsp_type               rsp_ff, rsp_in;

   logic [prc_pkg::ADDR_W-1:0]     addr;
   logic                           ram_we;
   prc_pkg::rec_type               ram_wdata;
   prc_pkg::rec_type               ram_rdata;
   prc_pkg::rec_type               rec_rd;
   logic [prc_pkg::MS_W-1:0]       elapsed;
   prc_pkg::interp_req_type        ireq;
   prc_pkg::interp_rsp_type        irsp;

   assign addr    = idx_ff[prc_pkg::ADDR_W-1:0];
   // an entry never written reads as the reset record
   assign rec_rd  = valid_ff[addr] ? ram_rdata : '0;
   assign elapsed = now_ff - rec_rd.start_ms;

   prc_ram #(
      .WIDTH ($bits(prc_pkg::rec_type)),
      .DEPTH (prc_pkg::CHANNELS)
   ) u_chan_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   prc_interp u_interp (
      .clock (clock),
      .reset (reset),
      .ireq  (ireq),
      .irsp  (irsp)
   );

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      now_in        = now_ff;
      ramping_in    = ramping_ff;
      valid_in      = valid_ff;
      rec_in        = rec_ff;
      duty_in       = duty_ff;
      pend_valid_in = pend_valid_ff;
      pend_ch_in    = pend_ch_ff;
      pend_duty_in  = pend_duty_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_wdata     = rec_rd;
      ireq.start    = 1'b0;
      ireq.start_d  = rec_rd.start_d;
      ireq.end_d    = rec_rd.end_d;
      ireq.len      = rec_rd.len;
      ireq.elapsed  = elapsed[prc_pkg::LEN_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               idx_in = '0;
               unique case (req_data.mode)
                  prc_pkg::MODE_RAMP, prc_pkg::MODE_LEVEL: begin
                     if ((prc_pkg::CNT_W + 1)'(req_data.channel) <
                         (prc_pkg::CNT_W + 1)'(prc_pkg::CHANNELS)) begin
                        idx_in   = prc_pkg::CNT_W'(req_data.channel);
                        state_in = ST_RD;
                     end
                  end
                  prc_pkg::MODE_BREAK: begin
                     state_in = ST_SCAN;
                  end
                  prc_pkg::MODE_TICK: begin
                     now_in   = now_ff + 1'b1;
                     state_in = ST_SCAN;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD: begin
            state_in = ST_LOOK;
         end
         ST_SCAN: begin
            if (idx_ff == prc_pkg::CNT_W'(prc_pkg::CHANNELS)) begin
               // flush the held result as the final one
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{out_channel: pend_ch_ff, duty: pend_duty_ff,
                                   last: 1'b1};
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end else if (ramping_ff[addr]) begin
               state_in = ST_LOOK;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_LOOK: begin
            unique case (req_ff.mode)
               prc_pkg::MODE_RAMP: begin
                  ram_wdata.start_d  = rec_rd.cur;
                  ram_wdata.end_d    = req_ff.target;
                  ram_wdata.start_ms = now_ff;
                  ram_wdata.len      = req_ff.duration_ms;
                  ram_we             = 1'b1;
                  ramping_in[addr]   = 1'b1;
                  valid_in[addr]     = 1'b1;
                  state_in           = ST_IDLE;
               end
               prc_pkg::MODE_LEVEL: begin
                  ram_wdata.cur    = req_ff.level ? prc_pkg::DUTY_FULL : '0;
                  ram_we           = 1'b1;
                  ramping_in[addr] = 1'b0;
                  valid_in[addr]   = 1'b1;
                  rsp_valid_in     = 1'b1;
                  rsp_in           = '{out_channel: req_ff.channel,
                                       duty: ram_wdata.cur, last: 1'b1};
                  state_in         = ST_IDLE;
               end
               prc_pkg::MODE_BREAK: begin
                  // freeze where it stands
                  ram_wdata.end_d = rec_rd.cur;
                  ram_we          = 1'b1;
                  valid_in[addr]  = 1'b1;
                  idx_in          = idx_ff + 1'b1;
                  state_in        = ST_SCAN;
               end
               prc_pkg::MODE_TICK: begin
                  rec_in = rec_rd;
                  if (rec_rd.cur == rec_rd.end_d) begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = ST_SCAN;
                  end else if (elapsed >= prc_pkg::MS_W'(rec_rd.len)) begin
                     duty_in  = rec_rd.end_d;
                     state_in = ST_UPD;
                  end else begin
                     ireq.start = 1'b1;
                     state_in   = ST_CALC;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_CALC: begin
            if (irsp.done) begin
               duty_in  = irsp.quotient;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            ram_wdata     = rec_ff;
            ram_wdata.cur = duty_ff;
            ram_we        = 1'b1;
            // emit the previous update now that another one follows it
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{out_channel: pend_ch_ff, duty: pend_duty_ff,
                                last: 1'b0};
            end
            pend_valid_in = 1'b1;
            pend_ch_in    = prc_pkg::CH_W'(idx_ff);
            pend_duty_in  = duty_ff;
            idx_in        = idx_ff + 1'b1;
            state_in      = ST_SCAN;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         now_ff        <= '0;
         ramping_ff    <= '0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         now_ff        <= now_in;
         ramping_ff    <= ramping_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff       <= req_in;
      rec_ff       <= rec_in;
      duty_ff      <= duty_in;
      pend_ch_ff   <= pend_ch_in;
      pend_duty_ff <= pend_duty_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/prc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module prc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                          wdata,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/prc_interp.sv
// ----------------------------------------------------------------------------
// Ramp interpolation unit
// Shift-add multiply then restoring divide, one bit per cycle, giving
// floor((s*(len-el) + e*el) / len) for el < len.
// ----------------------------------------------------------------------------
module prc_interp (
   input  logic                    clock,
   input  logic                    reset,
   input  prc_pkg::interp_req_type ireq,
   output prc_pkg::interp_rsp_type irsp
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV
   } state_type;

   state_type                        state_ff, state_in;
   logic [prc_pkg::MUL_W-1:0]        a_ff, a_in;
   logic [prc_pkg::MUL_W-1:0]        b_ff, b_in;
   logic [prc_pkg::DUTY_W-1:0]       s_ff, s_in;
   logic [prc_pkg::DUTY_W-1:0]       e_ff, e_in;
   logic [prc_pkg::LEN_W-1:0]        len_ff, len_in;
   logic [prc_pkg::MUL_W-1:0]        acc_ff, acc_in;
   logic [prc_pkg::MUL_W-1:0]        dsh_ff, dsh_in;
   logic [prc_pkg::DUTY_W-1:0]       q_ff, q_in;
   logic [prc_pkg::STEP_W-1:0]       cnt_ff, cnt_in;
   logic                             done_ff, done_in;
   logic [prc_pkg::MUL_W-1:0]        part_a, part_b;

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      s_in     = s_ff;
      e_in     = e_ff;
      len_in   = len_ff;
      acc_in   = acc_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      part_a   = s_ff[0] ? a_ff : '0;
      part_b   = e_ff[0] ? b_ff : '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (ireq.start) begin
               a_in     = prc_pkg::MUL_W'(ireq.len - ireq.elapsed);
               b_in     = prc_pkg::MUL_W'(ireq.elapsed);
               s_in     = ireq.start_d;
               e_in     = ireq.end_d;
               len_in   = ireq.len;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // add one bit of each duty weight, advance the multiplicands
            acc_in = acc_ff + part_a + part_b;
            a_in   = {a_ff[prc_pkg::MUL_W-2:0], 1'b0};
            b_in   = {b_ff[prc_pkg::MUL_W-2:0], 1'b0};
            s_in   = {1'b0, s_ff[prc_pkg::DUTY_W-1:1]};
            e_in   = {1'b0, e_ff[prc_pkg::DUTY_W-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == prc_pkg::STEP_W'(prc_pkg::DUTY_W - 1)) begin
               dsh_in   = prc_pkg::MUL_W'(len_ff) << (prc_pkg::DUTY_W - 1);
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // quotient stays below 2^DUTY_W, so DUTY_W steps suffice
            if (acc_ff >= dsh_ff) begin
               acc_in = acc_ff - dsh_ff;
               q_in   = {q_ff[prc_pkg::DUTY_W-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[prc_pkg::DUTY_W-2:0], 1'b0};
            end
            dsh_in = {1'b0, dsh_ff[prc_pkg::MUL_W-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == prc_pkg::STEP_W'(prc_pkg::DUTY_W - 1)) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      s_ff   <= s_in;
      e_ff   <= e_in;
      len_ff <= len_in;
      acc_ff <= acc_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign irsp.done     = done_ff;
   assign irsp.quotient = q_ff;

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// PWM ramp controller testbench
// Drives ramp, level, break and tick commands into the controller with
// random start gaps. A duty predictor with its own channel state works out
// the expected duty updates, and each update the block emits is checked
// against the oldest one still waiting.
// ----------------------------------------------------------------------------
module tb;
   import prc_pkg::*;

   localparam int ITEMS       = 290;
   localparam int QUIET_TAIL  = 40;        // last transfers go without gaps
   localparam int DRAIN_WAIT  = 1600;      // a full tick walk with no updates
   localparam int CYCLE_LIMIT = 2_000_000;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   pwm_ramp_controller_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // predicted channel state
   logic [MS_W-1:0]   ms_count;
   logic              ch_ramping [CHANNELS];
   logic [DUTY_W-1:0] ch_duty    [CHANNELS];
   logic [DUTY_W-1:0] ch_from    [CHANNELS];
   logic [DUTY_W-1:0] ch_to      [CHANNELS];
   logic [MS_W-1:0]   ch_t0      [CHANNELS];
   logic [LEN_W-1:0]  ch_len     [CHANNELS];

   req_type cmd_queue [$];
   rsp_type duty_updates [$];
   logic    taken = 1'b0;
   int      gap_left = 0;
   bit      gaps_on = 1'b1;
   int      error_count = 0;
   int      cycle_count = 0;

   initial begin
      ms_count = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         ch_ramping[i] = 1'b0;
         ch_duty[i]    = '0;
         ch_from[i]    = '0;
         ch_to[i]      = '0;
         ch_t0[i]      = '0;
         ch_len[i]     = '0;
      end
   end

   // linear fade position of one channel at the present millisecond count
   function automatic logic [DUTY_W-1:0] faded_duty(input int i);
      logic [31:0] elapsed;
      logic [31:0] span;
      logic [31:0] num;
      elapsed = ms_count - ch_t0[i];
      span    = 32'(ch_len[i]);
      if (elapsed >= span)
         return ch_to[i];
      num = 32'(ch_from[i]) * (span - elapsed) + 32'(ch_to[i]) * elapsed;
      return DUTY_W'(num / span);
   endfunction

   task automatic apply_command(input req_type cmd);
      rsp_type upd;
      int      first;
      first = duty_updates.size();
      case (cmd.mode)
         MODE_RAMP: begin
            ch_from[cmd.channel]    = ch_duty[cmd.channel];
            ch_to[cmd.channel]      = cmd.target;
            ch_t0[cmd.channel]      = ms_count;
            ch_len[cmd.channel]     = cmd.duration_ms;
            ch_ramping[cmd.channel] = 1'b1;
         end
         MODE_LEVEL: begin
            ch_ramping[cmd.channel] = 1'b0;
            ch_duty[cmd.channel]    = cmd.level ? DUTY_FULL : '0;
            upd.out_channel = cmd.channel;
            upd.duty        = ch_duty[cmd.channel];
            upd.last        = 1'b0;
            duty_updates.push_back(upd);
         end
         MODE_BREAK: begin
            for (int i = 0; i < CHANNELS; i++)
               if (ch_ramping[i])
                  ch_to[i] = ch_duty[i];
         end
         MODE_TICK: begin
            ms_count = ms_count + 1;
            for (int i = 0; i < CHANNELS; i++) begin
               if (ch_ramping[i] && ch_duty[i] != ch_to[i]) begin
                  ch_duty[i]      = faded_duty(i);
                  upd.out_channel = CH_W'(i);
                  upd.duty        = ch_duty[i];
                  upd.last        = 1'b0;
                  duty_updates.push_back(upd);
               end
            end
         end
      endcase
      // flag the final update of this command
      if (duty_updates.size() > first) begin
         upd = duty_updates.pop_back();
         upd.last = 1'b1;
         duty_updates.push_back(upd);
      end
   endtask

   function automatic req_type make_cmd(input logic [1:0] m, input int ch, input int tgt,
                                        input int dur, input bit lvl);
      req_type c;
      c.mode        = m;
      c.channel     = CH_W'(ch);
      c.target      = DUTY_W'(tgt);
      c.duration_ms = LEN_W'(dur);
      c.level       = lvl;
      return c;
   endfunction

   // every field but the mode random; mostly short fades so they finish within the run
   function automatic req_type random_cmd(input logic [1:0] m);
      req_type c;
      int      pick;
      c.mode    = m;
      c.channel = CH_W'($urandom_range(0, CHANNELS - 1));
      c.target  = DUTY_W'($urandom);
      c.level   = 1'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 6)
         c.duration_ms = LEN_W'($urandom_range(0, 15));
      else if (pick < 8)
         c.duration_ms = LEN_W'($urandom_range(16, 400));
      else
         c.duration_ms = LEN_W'($urandom_range(0, 65535));
      return c;
   endfunction

   // stimulus and end of run
   initial begin
      int n;
      // directed: field extremes, every command, zero-length and no-change fades
      cmd_queue.push_back(make_cmd(MODE_LEVEL, 0, 0, 0, 1'b1));
      cmd_queue.push_back(make_cmd(MODE_LEVEL, 63, 255, 65535, 1'b0));
      cmd_queue.push_back(make_cmd(MODE_RAMP, 0, 0, 0, 1'b0));
      cmd_queue.push_back(make_cmd(MODE_RAMP, 63, 255, 65535, 1'b1));
      cmd_queue.push_back(make_cmd(MODE_RAMP, 5, 0, 10, 1'b0));
      cmd_queue.push_back(make_cmd(MODE_RAMP, 1, 200, 3, 1'b0));
      cmd_queue.push_back(make_cmd(MODE_TICK, 0, 0, 0, 1'b0));
      cmd_queue.push_back(make_cmd(MODE_TICK, 63, 255, 65535, 1'b1));
      cmd_queue.push_back(make_cmd(MODE_BREAK, 0, 0, 0, 1'b0));
      cmd_queue.push_back(make_cmd(MODE_TICK, 0, 0, 0, 1'b0));
      cmd_queue.push_back(make_cmd(MODE_RAMP, 1, 255, 2, 1'b0));
      cmd_queue.push_back(make_cmd(MODE_TICK, 0, 0, 0, 1'b0));
      cmd_queue.push_back(make_cmd(MODE_TICK, 0, 0, 0, 1'b0));
      cmd_queue.push_back(make_cmd(MODE_TICK, 0, 0, 0, 1'b0));
      cmd_queue.push_back(make_cmd(MODE_LEVEL, 1, 0, 0, 1'b0));
      cmd_queue.push_back(make_cmd(MODE_RAMP, 2, 128, 1, 1'b0));
      cmd_queue.push_back(make_cmd(MODE_RAMP, 62, 254, 65534, 1'b0));
      cmd_queue.push_back(make_cmd(MODE_RAMP, 3, 1, 65535, 1'b0));
      cmd_queue.push_back(make_cmd(MODE_TICK, 0, 0, 0, 1'b0));
      cmd_queue.push_back(make_cmd(MODE_LEVEL, 62, 0, 0, 1'b1));
      cmd_queue.push_back(make_cmd(MODE_TICK, 0, 0, 0, 1'b0));
      cmd_queue.push_back(make_cmd(MODE_TICK, 0, 0, 0, 1'b0));

      // random: fade/level bursts, sometimes a break, a run of ticks, sometimes any mode
      while (cmd_queue.size() < ITEMS) begin
         n = $urandom_range(1, 4);
         repeat (n)
            cmd_queue.push_back(random_cmd(($urandom_range(0, 3) == 0) ? MODE_LEVEL : MODE_RAMP));
         if ($urandom_range(0, 7) == 0)
            cmd_queue.push_back(random_cmd(MODE_BREAK));
         n = $urandom_range(1, 12);
         repeat (n)
            cmd_queue.push_back(random_cmd(MODE_TICK));
         if ($urandom_range(0, 9) == 0)
            cmd_queue.push_back(random_cmd(2'($urandom)));
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() != 0 || start)
         @(posedge clock);
      while (duty_updates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // driver: hold each command until its transfer, then advance
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (cmd_queue.size() != 0) begin
            req_data <= cmd_queue.pop_front();
            start    <= 1'b1;
            if ($urandom_range(0, 15) == 0)
               gaps_on = ~gaps_on;
            if (gaps_on && cmd_queue.size() > QUIET_TAIL && $urandom_range(0, 2) == 0)
               gap_left <= $urandom_range(1, 8);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // predictor and checker
   always @(posedge clock) begin
      rsp_type want;
      taken <= !reset && start && !busy;
      if (!reset) begin
         if (start && !busy)
            apply_command(req_data);
         if (rsp_valid) begin
            if (duty_updates.size() == 0) begin
               $error("unexpected update: out_channel %0d duty %0d last %0b",
                      rsp_data.out_channel, rsp_data.duty, rsp_data.last);
               error_count++;
            end else begin
               want = duty_updates.pop_front();
               if (rsp_data.out_channel !== want.out_channel) begin
                  $error("out_channel: expected %0d, got %0d",
                         want.out_channel, rsp_data.out_channel);
                  error_count++;
               end
               if (rsp_data.duty !== want.duty) begin
                  $error("duty: expected %0d, got %0d", want.duty, rsp_data.duty);
                  error_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_data.last);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule
